### hdl/jsu_pkg.sv
// Shared types, codes and byte helpers for the JSON string unescape block.
package jsu_pkg;

  // Parser phase inside or outside a quoted string
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_HEX,
    PH_AFTER_HI,
    PH_AFTER_HI_BS,
    PH_LOHEX
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_BADESC  = 3'd3,
    ST_BADHEX  = 3'd4,
    ST_UNTERM  = 3'd5
  } status_e;

  // What the trailing part of one item's results is
  typedef enum logic [1:0] {
    TK_NONE,
    TK_RAW,
    TK_CP,
    TK_STATUS
  } tail_e;

  localparam int unsigned MaxWords = 4;
  localparam int unsigned CntW     = 3;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [15:0] HiFirst = 16'hD800;
  localparam logic [15:0] HiLast  = 16'hDBFF;
  localparam logic [15:0] LoFirst = 16'hDC00;
  localparam logic [15:0] LoLast  = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;

  // One input word
  typedef struct packed {
    logic       eoi;
    logic       start;
    logic [7:0] data;
  } item_t;

  // One result word
  typedef struct packed {
    status_e    status;
    logic [7:0] data;
  } word_t;

  // All results caused by one input word
  typedef struct packed {
    word_t [MaxWords-1:0] w;
    logic  [CntW-1:0]     cnt;
  } batch_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  // Decode one hex digit, either case
  function automatic hex_t hex_map(input logic [7:0] b);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.val = 4'(b - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Translate a simple escape character
  function automatic esc_t esc_map(input logic [7:0] b);
    esc_t r;
    r.ok = 1'b1;
    case (b)
      8'h22:   r.ch = 8'h22;
      8'h5C:   r.ch = 8'h5C;
      8'h2F:   r.ch = 8'h2F;
      8'h62:   r.ch = 8'h08;
      8'h66:   r.ch = 8'h0C;
      8'h6E:   r.ch = 8'h0A;
      8'h72:   r.ch = 8'h0D;
      8'h74:   r.ch = 8'h09;
      default: begin
        r.ok = 1'b0;
        r.ch = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

### hdl/jsu_utf8.sv
// UTF-8 encoder: one code point to up to four byte words.
module jsu_utf8 (
  input  logic [20:0]                         cp_i,
  output jsu_pkg::word_t [jsu_pkg::MaxWords-1:0] w_o,
  output logic [jsu_pkg::CntW-1:0]            cnt_o
);
  import jsu_pkg::*;

  // Pick the sequence length and fill the bytes
  always_comb begin
    for (int i = 0; i < MaxWords; i++) begin
      w_o[i].status = ST_BYTE;
      w_o[i].data   = 8'h00;
    end
    if (cp_i < 21'h80) begin
      w_o[0].data = cp_i[7:0];
      cnt_o       = CntW'(1);
    end else if (cp_i < 21'h800) begin
      w_o[0].data = {3'b110, cp_i[10:6]};
      w_o[1].data = {2'b10, cp_i[5:0]};
      cnt_o       = CntW'(2);
    end else if (cp_i < SuppBase) begin
      w_o[0].data = {4'b1110, cp_i[15:12]};
      w_o[1].data = {2'b10, cp_i[11:6]};
      w_o[2].data = {2'b10, cp_i[5:0]};
      cnt_o       = CntW'(3);
    end else begin
      w_o[0].data = {5'b11110, cp_i[20:18]};
      w_o[1].data = {2'b10, cp_i[17:12]};
      w_o[2].data = {2'b10, cp_i[11:6]};
      w_o[3].data = {2'b10, cp_i[5:0]};
      cnt_o       = CntW'(4);
    end
  end

endmodule

### hdl/jsu_decode.sv
// Parser state and per-word decode into a batch of result words.
module jsu_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  jsu_pkg::item_t  item_i,
  output jsu_pkg::batch_t batch_o
);
  import jsu_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] accum_q, accum_d;
  logic [1:0]  digit_q, digit_d;
  logic [15:0] held_q, held_d;

  logic [7:0]  b;
  logic        is_quote, is_bs, is_u, last_digit, hi_range, lo_range;
  hex_t        hx;
  esc_t        esc;
  logic [15:0] accum_n;
  logic [20:0] comb_cp;

  tail_e       str_kind, esc_kind, tail_kind;
  status_e     str_status, esc_status, tail_status;
  logic [7:0]  esc_byte, tail_byte;
  logic [20:0] tail_cp;
  logic        prefix;
  phase_e      str_next, esc_next;

  word_t [MaxWords-1:0] cp_w, tw;
  logic  [CntW-1:0]     cp_n, tn;

  // Byte classification shared by the blocks below
  assign b          = item_i.data;
  assign is_quote   = (b == ChQuote);
  assign is_bs      = (b == ChBslash);
  assign is_u       = (b == ChU);
  assign hx         = hex_map(b);
  assign esc        = esc_map(b);
  assign accum_n    = {accum_q[11:0], hx.val};
  assign last_digit = (digit_q == 2'd3);
  assign hi_range   = (accum_n >= HiFirst) && (accum_n <= HiLast);
  assign lo_range   = (accum_n >= LoFirst) && (accum_n <= LoLast);
  assign comb_cp    = SuppBase + {1'b0, held_q[9:0], accum_n[9:0]};

  // String-body and escape handling, used from several phases
  always_comb begin
    str_kind   = TK_RAW;
    str_status = ST_BYTE;
    str_next   = PH_STR;
    if (is_quote) begin
      str_kind   = TK_STATUS;
      str_status = ST_DONE;
      str_next   = PH_IDLE;
    end else if (is_bs) begin
      str_kind = TK_NONE;
      str_next = PH_ESC;
    end
    esc_kind   = TK_RAW;
    esc_status = ST_BYTE;
    esc_byte   = esc.ch;
    esc_next   = PH_STR;
    if (!esc.ok) begin
      if (is_u) begin
        esc_kind = TK_NONE;
        esc_next = PH_HEX;
      end else begin
        esc_kind   = TK_STATUS;
        esc_status = ST_BADESC;
        esc_next   = PH_IDLE;
      end
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    digit_d = digit_q;
    held_d  = held_q;
    if (item_i.eoi) begin
      phase_d = PH_IDLE;
    end else if (item_i.start) begin
      accum_d = 16'h0000;
      digit_d = 2'd0;
      phase_d = is_quote ? PH_STR : PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_STR: phase_d = str_next;
        PH_ESC: begin
          phase_d = esc_next;
          if (esc_next == PH_HEX) begin
            accum_d = 16'h0000;
            digit_d = 2'd0;
          end
        end
        PH_HEX, PH_LOHEX: begin
          if (!hx.ok) begin
            phase_d = PH_IDLE;
          end else begin
            accum_d = accum_n;
            if (!last_digit) begin
              digit_d = digit_q + 2'd1;
            end else begin
              digit_d = 2'd0;
              phase_d = PH_STR;
              if (phase_q == PH_HEX && hi_range) begin
                held_d  = accum_n;
                phase_d = PH_AFTER_HI;
              end
            end
          end
        end
        PH_AFTER_HI: phase_d = is_bs ? PH_AFTER_HI_BS : str_next;
        PH_AFTER_HI_BS: begin
          if (is_u) begin
            accum_d = 16'h0000;
            digit_d = 2'd0;
            phase_d = PH_LOHEX;
          end else begin
            phase_d = esc_next;
          end
        end
        PH_IDLE: phase_d = PH_IDLE;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Outputs: optional held high half, then the tail
  always_comb begin
    prefix      = 1'b0;
    tail_kind   = TK_NONE;
    tail_status = ST_BYTE;
    tail_byte   = b;
    tail_cp     = {5'd0, accum_n};
    if (item_i.eoi) begin
      if (phase_q == PH_IDLE) begin
        if (item_i.start) begin
          tail_kind   = TK_STATUS;
          tail_status = ST_NOQUOTE;
        end
      end else begin
        prefix      = (phase_q == PH_AFTER_HI) || (phase_q == PH_AFTER_HI_BS);
        tail_kind   = TK_STATUS;
        tail_status = ST_UNTERM;
      end
    end else if (item_i.start) begin
      if (!is_quote) begin
        tail_kind   = TK_STATUS;
        tail_status = ST_NOQUOTE;
      end
    end else begin
      unique case (phase_q)
        PH_STR: begin
          tail_kind   = str_kind;
          tail_status = str_status;
        end
        PH_ESC: begin
          tail_kind   = esc_kind;
          tail_status = esc_status;
          tail_byte   = esc_byte;
        end
        PH_HEX: begin
          if (!hx.ok) begin
            tail_kind   = TK_STATUS;
            tail_status = ST_BADHEX;
          end else if (last_digit && !hi_range) begin
            tail_kind = TK_CP;
          end
        end
        PH_LOHEX: begin
          if (!hx.ok) begin
            prefix      = 1'b1;
            tail_kind   = TK_STATUS;
            tail_status = ST_BADHEX;
          end else if (last_digit) begin
            if (lo_range) begin
              tail_kind = TK_CP;
              tail_cp   = comb_cp;
            end else begin
              prefix = 1'b1;
            end
          end
        end
        PH_AFTER_HI: begin
          if (!is_bs) begin
            prefix      = 1'b1;
            tail_kind   = str_kind;
            tail_status = str_status;
          end
        end
        PH_AFTER_HI_BS: begin
          if (!is_u) begin
            prefix      = 1'b1;
            tail_kind   = esc_kind;
            tail_status = esc_status;
            tail_byte   = esc_byte;
          end
        end
        PH_IDLE: tail_kind = TK_NONE;
        default: tail_kind = TK_NONE;
      endcase
    end
  end

  jsu_utf8 u_utf8 (
    .cp_i  (tail_cp),
    .w_o   (cp_w),
    .cnt_o (cp_n)
  );

  // Build tail words
  always_comb begin
    for (int i = 0; i < MaxWords; i++) begin
      tw[i].status = ST_BYTE;
      tw[i].data   = 8'h00;
    end
    tn = CntW'(0);
    case (tail_kind)
      TK_RAW: begin
        tw[0].data = tail_byte;
        tn         = CntW'(1);
      end
      TK_STATUS: begin
        tw[0].status = tail_status;
        tn           = CntW'(1);
      end
      TK_CP: begin
        tw = cp_w;
        tn = cp_n;
      end
      default: tn = CntW'(0);
    endcase
  end

  // Place the held high half ahead of the tail
  always_comb begin
    batch_o.w   = tw;
    batch_o.cnt = tn;
    if (prefix) begin
      batch_o.w[0].status = ST_BYTE;
      batch_o.w[0].data   = {4'b1110, held_q[15:12]};
      batch_o.w[1].status = ST_BYTE;
      batch_o.w[1].data   = {2'b10, held_q[11:6]};
      batch_o.w[2].status = ST_BYTE;
      batch_o.w[2].data   = {2'b10, held_q[5:0]};
      batch_o.w[3]        = tw[0];
      batch_o.cnt         = CntW'(3) + tn;
    end
  end

  // Advance state on each consumed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      accum_q <= 16'h0000;
      digit_q <= 2'd0;
      held_q  <= 16'h0000;
    end else if (fire_i) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      digit_q <= digit_d;
      held_q  <= held_d;
    end
  end

endmodule

### hdl/jsu_out.sv
// Result register: holds one batch and sends it out a word at a time.
module jsu_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jsu_pkg::batch_t batch_i,
  output logic            load_ready_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output jsu_pkg::word_t  m_word_o,
  output logic            m_last_o
);
  import jsu_pkg::*;

  word_t [MaxWords-1:0] words_q;
  logic  [CntW-1:0]     cnt_q;
  logic  [1:0]          idx_q;
  logic                 send;

  assign m_valid_o    = (cnt_q != CntW'(0));
  assign m_last_o     = (cnt_q == CntW'(1));
  assign m_word_o     = words_q[idx_q];
  assign send         = m_valid_o && m_ready_i;
  assign load_ready_o = !m_valid_o || (m_last_o && m_ready_i);

  // Hold the batch words
  always_ff @(posedge clk_i) begin
    if (load_i && load_ready_o && batch_i.cnt != CntW'(0)) begin
      words_q <= batch_i.w;
    end
  end

  // Count down the words still to send
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(0);
      idx_q <= 2'd0;
    end else if (load_i && load_ready_o && batch_i.cnt != CntW'(0)) begin
      cnt_q <= batch_i.cnt;
      idx_q <= 2'd0;
    end else if (send) begin
      cnt_q <= cnt_q - CntW'(1);
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

### hdl/json_string_unescape_utf8.sv
// Streaming JSON string unescaper with UTF-8 output. Each input word goes
// into an input register, is decoded combinationally against the parser
// state and lands as a batch of up to four result words in the output
// register, which sends one word per cycle while the output is ready. A word
// that yields zero or one result does not hold up the next one, so plain
// text flows at one byte per clock while the output is ready; a word that
// yields n results (n is at most four, for a code point above U+FFFF or a
// held surrogate plus one more word) stalls the input until its last result
// goes out. tlast on the output marks the final result of an input word.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser_i,   // [0] start_string, [1] end_of_input
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser_o,   // [2:0] status
  output logic       m_axis_tlast_o
);
  import jsu_pkg::*;

  logic   in_valid_q;
  item_t  item_q;
  logic   load_ready, fire;
  batch_t batch;
  word_t  m_word;

  assign s_axis_tready_o = !in_valid_q || load_ready;
  assign fire            = in_valid_q && load_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q <= '{eoi: s_axis_tuser_i[1], start: s_axis_tuser_i[0], data: s_axis_tdata_i};
    end
  end

  jsu_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (item_q),
    .batch_o (batch)
  );

  jsu_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_valid_q),
    .batch_i      (batch),
    .load_ready_o (load_ready),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_word_o     (m_word),
    .m_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = m_word.data;
  assign m_axis_tuser_o = m_word.status;

  // A status word always closes the results of its input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_BYTE |-> m_axis_tlast_o)
    else $error("status word not last of its batch");

  // Status words carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_BYTE |-> m_axis_tdata_o == 8'h00)
    else $error("status word with nonzero data");

  // A waiting input word stays until the output can take its batch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !load_ready |=> in_valid_q && $stable(item_q))
    else $error("input word lost while output busy");

endmodule
